// ===== rtl/core/aesf_pkg.sv =====
// Shared types, constants and byte-class helpers for the ANSI escape filter.
// No dependencies; used by the controller, the datapath and the top level.
package aesf_pkg;

  // Sequence buffer and kept-byte counter sizing
  localparam int SEQ_BUFFER_DEPTH = 32;
  localparam int COUNT_BITS       = 16;
  localparam int FILL_W           = $clog2(SEQ_BUFFER_DEPTH + 1);
  localparam int ADDR_W           = $clog2(SEQ_BUFFER_DEPTH);

  // Special bytes
  localparam logic [7:0] ESC_BYTE    = 8'h1B;
  localparam logic [7:0] BEL_BYTE    = 8'h07;
  localparam logic [7:0] CSI_OPEN    = 8'h5B;  // '['
  localparam logic [7:0] OSC_OPEN    = 8'h5D;  // ']'
  localparam logic [7:0] ST_BSLASH   = 8'h5C;  // '\'
  localparam logic [7:0] SGR_FINAL   = 8'h6D;  // 'm'

  // strip_mode codes
  localparam logic [1:0] MODE_STRIP_ALL  = 2'd0;
  localparam logic [1:0] MODE_KEEP_COLOR = 2'd1;
  localparam logic [1:0] MODE_KEEP_SAFE  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic push;         // store the input byte in the sequence buffer
    logic clr_fill;     // empty the buffer and clear overflow (before a push)
    logic emit_in;      // pass the input byte on as the last beat
    logic emit_term;    // terminator beat, then clear the kept count
    logic flush_start;  // latch the final byte, read buffer entry 0
    logic flush_step;   // pass on the buffered byte, read the next one
    logic flush_fin;    // pass on the final byte as the last beat
  } aesf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_zero;
    logic is_esc;
    logic is_csi_open;
    logic is_osc_open;
    logic is_esc3;
    logic is_bel;
    logic is_bslash;
    logic is_final;     // 0x40-0x7E
    logic is_inter;     // 0x20-0x2F
    logic is_param;     // 0x30-0x3F
    logic is_priv;      // 0x3C-0x3F
    logic is_sgr;
    logic is_safe;
    logic overflow;
    logic flush_more;   // buffer entries left after the one being read
    logic slot_free;    // output register can take a beat this cycle
  } aesf_stat_t;

  // Finals kept in keep-safe mode: A B C D H I J K f h l m s u
  function automatic logic safe_final(input logic [7:0] c);
    logic hit;
    unique case (c)
      8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h49, 8'h4A, 8'h4B,
      8'h66, 8'h68, 8'h6C, 8'h6D, 8'h73, 8'h75: hit = 1'b1;
      default:                                 hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Second byte of a three-byte escape: ( ) * + - . / #
  function automatic logic esc3_intro(input logic [7:0] c);
    logic hit;
    unique case (c)
      8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F, 8'h23: hit = 1'b1;
      default:                                               hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/core/aesf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/aesf_dpath.sv =====
// Datapath: byte classification, sequence buffer, kept-byte counter, output register.
// Depends on aesf_pkg and aesf_ram.
module aesf_dpath
  import aesf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            text_byte,
  input  aesf_cmd_t             cmd,
  output aesf_stat_t            stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            data_byte,
  output logic                  byte_valid,
  output logic                  run_last,
  output logic                  string_done,
  output logic [15:0]           kept_count
);

  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     fill_next;
  logic [FILL_W-1:0]     fill_base;
  logic                  overflow;
  logic                  overflow_next;
  logic [FILL_W-1:0]     idx;
  logic [FILL_W-1:0]     idx_inc;
  logic [7:0]            final_byte;
  logic [COUNT_BITS-1:0] count;
  logic                  buf_full;
  logic                  wr_en;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [7:0]            rd_data;
  logic                  slot_free;
  logic                  load_byte;
  logic [7:0]            load_data;
  logic                  load_last;

  assign slot_free = !out_valid || out_ready;
  assign idx_inc   = idx + FILL_W'(1);

  // Byte classes of the input byte
  always_comb begin
    stat             = '0;
    stat.is_zero     = (text_byte == 8'h00);
    stat.is_esc      = (text_byte == ESC_BYTE);
    stat.is_csi_open = (text_byte == CSI_OPEN);
    stat.is_osc_open = (text_byte == OSC_OPEN);
    stat.is_esc3     = esc3_intro(text_byte);
    stat.is_bel      = (text_byte == BEL_BYTE);
    stat.is_bslash   = (text_byte == ST_BSLASH);
    stat.is_final    = (text_byte >= 8'h40) && (text_byte <= 8'h7E);
    stat.is_inter    = (text_byte >= 8'h20) && (text_byte <= 8'h2F);
    stat.is_param    = (text_byte >= 8'h30) && (text_byte <= 8'h3F);
    stat.is_priv     = (text_byte >= 8'h3C) && (text_byte <= 8'h3F);
    stat.is_sgr      = (text_byte == SGR_FINAL);
    stat.is_safe     = safe_final(text_byte);
    stat.overflow    = overflow;
    stat.flush_more  = (idx_inc < fill);
    stat.slot_free   = slot_free;
  end

  // Buffer fill and overflow tracking
  always_comb begin
    fill_base     = cmd.clr_fill ? '0 : fill;
    buf_full      = (fill_base >= FILL_W'(SEQ_BUFFER_DEPTH));
    wr_en         = cmd.push && !buf_full;
    fill_next     = fill_base;
    overflow_next = cmd.clr_fill ? 1'b0 : overflow;
    if (cmd.push) begin
      if (buf_full) begin
        overflow_next = 1'b1;
      end else begin
        fill_next = fill_base + FILL_W'(1);
      end
    end
    if (cmd.emit_term || cmd.flush_fin) begin
      fill_next     = '0;
      overflow_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
    end else begin
      fill     <= fill_next;
      overflow <= overflow_next;
    end
  end

  // Flush read pointer and latched final byte
  assign rd_en   = cmd.flush_start || (cmd.flush_step && stat.flush_more);
  assign rd_addr = cmd.flush_start ? '0 : idx_inc[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      idx        <= '0;
      final_byte <= text_byte;
    end else if (cmd.flush_step && stat.flush_more) begin
      idx <= idx_inc;
    end
  end

  aesf_ram #(
    .WIDTH(8),
    .DEPTH(SEQ_BUFFER_DEPTH)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill_base[ADDR_W-1:0]),
    .wr_data(text_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Byte beat source select
  always_comb begin
    load_byte = cmd.emit_in || cmd.flush_step || cmd.flush_fin;
    load_last = cmd.emit_in || cmd.flush_fin;
    priority if (cmd.flush_step) begin
      load_data = rd_data;
    end else if (cmd.flush_fin) begin
      load_data = final_byte;
    end else begin
      load_data = text_byte;
    end
  end

  // Saturating kept-byte counter, cleared by the terminator
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_term) begin
      count <= '0;
    end else if (load_byte && (count != {COUNT_BITS{1'b1}})) begin
      count <= count + COUNT_BITS'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || cmd.emit_term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      data_byte   <= load_data;
      byte_valid  <= 1'b1;
      run_last    <= load_last;
      string_done <= 1'b0;
      kept_count  <= '0;
    end else if (cmd.emit_term) begin
      data_byte   <= '0;
      byte_valid  <= 1'b0;
      run_last    <= 1'b1;
      string_done <= 1'b1;
      kept_count  <= 16'(count);
    end
  end

endmodule

// ===== rtl/core/aesf_ctrl.sv =====
// Controller: escape-sequence parser state machine, mode register and input handshake.
// Depends on aesf_pkg.
module aesf_ctrl
  import aesf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  aesf_stat_t stat,
  output aesf_cmd_t  cmd
);

  localparam logic [3:0] S_TEXT      = 4'd0;
  localparam logic [3:0] S_ESC       = 4'd1;
  localparam logic [3:0] S_CSI_ENTRY = 4'd2;
  localparam logic [3:0] S_CSI_BODY  = 4'd3;
  localparam logic [3:0] S_OSC       = 4'd4;
  localparam logic [3:0] S_OSC_ESC   = 4'd5;
  localparam logic [3:0] S_ESC3      = 4'd6;
  localparam logic [3:0] S_FLUSH     = 4'd7;
  localparam logic [3:0] S_FLUSH_FIN = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] strip_mode;
  logic       private_flag;
  logic       private_flag_next;
  logic       in_intermediates;
  logic       in_intermediates_next;
  logic       flushing;
  logic       accept;
  logic       strict;
  logic       keep;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_mode <= MODE_STRIP_ALL;
    end else if (cfg_wr_en) begin
      strip_mode <= cfg_wr_data;
    end
  end

  assign flushing = (state == S_FLUSH) || (state == S_FLUSH_FIN);
  assign in_ready = stat.slot_free && !flushing;
  assign accept   = in_valid && in_ready;
  assign strict   = (strip_mode == MODE_KEEP_COLOR) || (strip_mode == MODE_KEEP_SAFE);

  // Keep decision at a CSI final
  always_comb begin
    keep = 1'b0;
    if (strict && !private_flag && !stat.overflow) begin
      keep = (strip_mode == MODE_KEEP_COLOR) ? stat.is_sgr : stat.is_safe;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next            = state;
    private_flag_next     = private_flag;
    in_intermediates_next = in_intermediates;
    cmd                   = '0;
    if (accept) begin
      if (stat.is_zero) begin
        cmd.emit_term         = 1'b1;
        state_next            = S_TEXT;
        private_flag_next     = 1'b0;
        in_intermediates_next = 1'b0;
      end else begin
        unique case (state)
          S_ESC: begin
            priority if (stat.is_csi_open) begin
              cmd.push              = 1'b1;
              private_flag_next     = 1'b0;
              in_intermediates_next = 1'b0;
              state_next            = S_CSI_ENTRY;
            end else if (stat.is_osc_open) begin
              state_next = S_OSC;
            end else if (stat.is_esc3) begin
              state_next = S_ESC3;
            end else begin
              state_next = S_TEXT;
            end
          end
          S_ESC3: begin
            state_next = S_TEXT;
          end
          S_OSC, S_OSC_ESC: begin
            priority if ((state == S_OSC_ESC) && stat.is_bslash) begin
              state_next = S_TEXT;
            end else if (stat.is_bel) begin
              state_next = S_TEXT;
            end else if (stat.is_esc) begin
              state_next = S_OSC_ESC;
            end else begin
              state_next = S_OSC;
            end
          end
          S_CSI_ENTRY, S_CSI_BODY: begin
            if ((state == S_CSI_ENTRY) && stat.is_priv) begin
              private_flag_next = 1'b1;
            end
            state_next = S_CSI_BODY;
            priority if (stat.is_final) begin
              if (keep) begin
                cmd.flush_start = 1'b1;
                state_next      = S_FLUSH;
              end else begin
                cmd.clr_fill = 1'b1;
                state_next   = S_TEXT;
              end
            end else if (stat.is_inter) begin
              in_intermediates_next = 1'b1;
              cmd.push              = 1'b1;
            end else if (stat.is_param && !(strict && in_intermediates)) begin
              cmd.push = 1'b1;
            end else begin
              // malformed: drop the sequence, rescan this byte as text
              cmd.clr_fill = 1'b1;
              if (stat.is_esc) begin
                cmd.push   = 1'b1;
                state_next = S_ESC;
              end else begin
                cmd.emit_in = 1'b1;
                state_next  = S_TEXT;
              end
            end
          end
          S_FLUSH, S_FLUSH_FIN: begin
            state_next = state;  // not reachable with accept high
          end
          default: begin
            if (stat.is_esc) begin
              cmd.clr_fill = 1'b1;
              cmd.push     = 1'b1;
              state_next   = S_ESC;
            end else begin
              cmd.emit_in = 1'b1;
              state_next  = S_TEXT;
            end
          end
        endcase
      end
    end else if ((state == S_FLUSH) && stat.slot_free) begin
      cmd.flush_step = 1'b1;
      if (!stat.flush_more) begin
        state_next = S_FLUSH_FIN;
      end
    end else if ((state == S_FLUSH_FIN) && stat.slot_free) begin
      cmd.flush_fin = 1'b1;
      state_next    = S_TEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_TEXT;
      private_flag     <= 1'b0;
      in_intermediates <= 1'b0;
    end else begin
      state            <= state_next;
      private_flag     <= private_flag_next;
      in_intermediates <= in_intermediates_next;
    end
  end

endmodule

// ===== rtl/core/ansi_escape_sequence_filter.sv =====
// Top level of the ANSI escape sequence filter: controller plus datapath.
// Depends on aesf_pkg, aesf_ctrl, aesf_dpath (and aesf_ram through the datapath).
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   input   | in        | in_valid / in_ready    | text_byte
//   output  | out       | out_valid / out_ready  | data_byte byte_valid run_last
//           |           |                        | string_done kept_count
//   config  | in        | cfg_wr_en (no wait)    | cfg_wr_data (strip_mode)
//
// A plain text byte, a dropped byte or a terminator is handled as it is taken; bytes
// can follow every cycle while the output register drains.
// A kept CSI is replayed from the sequence buffer one beat per cycle while the output
// register drains, its stored bytes and then the final; input is held off.
// in_ready follows out_ready through the single output register.
// rst is synchronous: it clears parser state, mode, fill and count.
module ansi_escape_sequence_filter
  import aesf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        string_done,
  output logic [15:0] kept_count
);

  aesf_cmd_t  cmd;
  aesf_stat_t stat;

  aesf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  aesf_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .text_byte  (text_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_done(string_done),
    .kept_count (kept_count)
  );

endmodule

// ===== rtl/core/aesf_sva.sv =====
// Port-level checks for the ANSI escape sequence filter, bound to the top level.
// Depends on ansi_escape_sequence_filter.
module aesf_sva (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  text_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_byte,
  input logic        byte_valid,
  input logic        run_last,
  input logic        string_done,
  input logic [15:0] kept_count
);

  // A zero byte taken produces the terminator beat next
  a_term_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (text_byte == 8'h00) |=> out_valid && string_done)
    else $error("zero byte accepted without terminator beat");

  // Every beat without a data byte is a last terminator beat, and vice versa
  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != string_done) && (!string_done || run_last))
    else $error("malformed terminator beat");

  // Mid-burst beats keep input held off until the burst ends
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> !in_ready)
    else $error("input taken during a kept-sequence burst");

  // Stalled beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(run_last)
      && $stable(string_done) && $stable(kept_count))
    else $error("output beat changed while stalled");

endmodule

bind ansi_escape_sequence_filter aesf_sva u_sva (.*);
